// ===== sv/reld_pkg.sv =====
`timescale 1ns / 1ps

package reld_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned TIME_W     = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_GAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTARY_GAP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_LEVEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RESTORE_LEVEL = 3'd4;

  // Reset values.
  localparam logic [GAP_W-1:0]   RST_BUTTON_GAP    = 16'd20;
  localparam logic [GAP_W-1:0]   RST_ROTARY_GAP    = 16'd5;
  localparam logic [LEVEL_W-1:0] RST_LEVEL_STEP    = 10'd50;
  localparam logic [LEVEL_W-1:0] RST_FULL_LEVEL    = 10'd1000;
  localparam logic [LEVEL_W-1:0] RST_RESTORE_LEVEL = 10'd500;

  // Event kinds.
  localparam logic MODE_SWITCH  = 1'b0;
  localparam logic MODE_ENCODER = 1'b1;

  // Encoder direction as given by the B level.
  localparam logic DIR_UP   = 1'b0;
  localparam logic DIR_DOWN = 1'b1;

  typedef struct packed {
    logic [GAP_W-1:0]   button_gap;
    logic [GAP_W-1:0]   rotary_gap;
    logic [LEVEL_W-1:0] level_step;
    logic [LEVEL_W-1:0] full_level;
    logic [LEVEL_W-1:0] restore_level;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]  last_button_time;
    logic [TIME_W-1:0]  last_rotary_time;
    logic               press_flag;
    logic               lamp_state;
    logic [LEVEL_W-1:0] stored_level;
  } state_t;

  typedef struct packed {
    logic              mode;
    logic              b_level;
    logic [TIME_W-1:0] time_ms;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               lamp_on;
    logic               level_written;
    logic               accepted;
  } result_t;

endpackage

// ===== sv/reld_step.sv =====
`timescale 1ns / 1ps

// Next state and result for one pin event, given the current state.
module reld_step (
  input  reld_pkg::cfg_t    cfg,
  input  reld_pkg::state_t  cur,
  input  reld_pkg::item_t   item,
  output reld_pkg::state_t  nxt,
  output reld_pkg::result_t res
);

  logic [reld_pkg::TIME_W-1:0]  btn_delta;
  logic [reld_pkg::TIME_W-1:0]  rot_delta;
  logic                         btn_ok;
  logic                         rot_ok;
  logic [reld_pkg::LEVEL_W:0]   up_sum;
  logic [reld_pkg::LEVEL_W-1:0] lv_enc;
  logic                         accepted;
  logic                         written;

  assign btn_delta = item.time_ms - cur.last_button_time;
  assign rot_delta = item.time_ms - cur.last_rotary_time;
  assign btn_ok = btn_delta >= {{(reld_pkg::TIME_W-reld_pkg::GAP_W){1'b0}}, cfg.button_gap};
  assign rot_ok = rot_delta >= {{(reld_pkg::TIME_W-reld_pkg::GAP_W){1'b0}}, cfg.rotary_gap};
  assign up_sum = {1'b0, cur.stored_level} + {1'b0, cfg.level_step};

  // Encoder step with clamping to the range zero to full level.
  always_comb begin
    lv_enc = cur.stored_level;
    if ((item.b_level == reld_pkg::DIR_UP) && (cur.stored_level < cfg.full_level)) begin
      if (up_sum >= {1'b0, cfg.full_level}) begin
        lv_enc = cfg.full_level;
      end else begin
        lv_enc = up_sum[reld_pkg::LEVEL_W-1:0];
      end
    end else if ((item.b_level == reld_pkg::DIR_DOWN) && (cur.stored_level != '0)) begin
      if (cur.stored_level <= cfg.level_step) begin
        lv_enc = '0;
      end else begin
        lv_enc = cur.stored_level - cfg.level_step;
      end
    end
  end

  always_comb begin
    nxt      = cur;
    accepted = 1'b0;
    written  = 1'b0;
    if (item.mode == reld_pkg::MODE_SWITCH) begin
      if (btn_ok) begin
        accepted             = 1'b1;
        nxt.last_button_time = item.time_ms;
        if (!cur.press_flag) begin
          nxt.press_flag = 1'b1;
          written        = 1'b1;
          if (!cur.lamp_state) begin
            nxt.lamp_state = 1'b1;
          end else if (cur.stored_level == '0) begin
            nxt.stored_level = cfg.restore_level;
          end else begin
            nxt.lamp_state = 1'b0;
          end
        end else begin
          nxt.press_flag = 1'b0;
        end
      end
    end else begin
      if (rot_ok) begin
        accepted             = 1'b1;
        nxt.last_rotary_time = item.time_ms;
        if (cur.lamp_state) begin
          nxt.stored_level = lv_enc;
          written          = 1'b1;
        end
      end
    end
  end

  assign res.level         = nxt.lamp_state ? nxt.stored_level : '0;
  assign res.lamp_on       = nxt.lamp_state;
  assign res.level_written = written;
  assign res.accepted      = accepted;

endmodule

// ===== sv/rotary_encoder_led_dimmer_unit.sv =====
`timescale 1ns / 1ps

// Rotary-encoder LED dimmer. Each input transfer is one pin event: a push-switch
// falling edge (mode 0) or an encoder A rising edge with the B level (mode 1),
// stamped with a millisecond time that wraps modulo 2^32. Each kind of event is
// debounced against its own minimum gap, measured from the last event of that
// kind that passed; events inside the gap are dropped but still give a result.
// Accepted presses alternate between acting and merely clearing a pressed flag.
// An acting press switches the lamp on at the stored level, restores the
// restore level if the lamp is on at zero, and otherwise switches it off.
// Encoder steps while the lamp is on move the level by the step size, clamped
// to the range zero to full level. Every event yields exactly one result
// transfer. An event is captured in an input register, evaluated against the
// held state combinationally, and its result lands in an output register, so
// the block takes one event per clock cycle while the output is not stalled.
// The input side stalls only when both the input and output registers are
// occupied and the output is stalled. Configuration registers are written
// through the cfg_ port and should only change while no event is in flight;
// a write to the full level leaves the stored level as is.
module rotary_encoder_led_dimmer_unit (
  input  logic                               clk,
  input  logic                               rst_n,

  input  logic                               cfg_we,
  input  logic [reld_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [reld_pkg::CFG_DATA_W-1:0]    cfg_data,

  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_mode,
  input  logic                               in_b_level,
  input  logic [reld_pkg::TIME_W-1:0]        in_time_ms,

  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [reld_pkg::LEVEL_W-1:0]       out_level,
  output logic                               out_lamp_on,
  output logic                               out_level_written,
  output logic                               out_accepted
);

  reld_pkg::cfg_t    cfg_r;
  reld_pkg::state_t  state_r;
  reld_pkg::state_t  state_nxt;
  reld_pkg::item_t   item_r;
  reld_pkg::result_t res_r;
  reld_pkg::result_t res_nxt;
  logic              item_vld_r;
  logic              out_vld_r;
  logic              advance;
  logic              in_take;

  // The held event moves on when the output register is free or being emptied.
  assign advance  = item_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = item_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_gap    <= reld_pkg::RST_BUTTON_GAP;
      cfg_r.rotary_gap    <= reld_pkg::RST_ROTARY_GAP;
      cfg_r.level_step    <= reld_pkg::RST_LEVEL_STEP;
      cfg_r.full_level    <= reld_pkg::RST_FULL_LEVEL;
      cfg_r.restore_level <= reld_pkg::RST_RESTORE_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        reld_pkg::CFG_BUTTON_GAP:    cfg_r.button_gap    <= cfg_data;
        reld_pkg::CFG_ROTARY_GAP:    cfg_r.rotary_gap    <= cfg_data;
        reld_pkg::CFG_LEVEL_STEP:    cfg_r.level_step    <= cfg_data[reld_pkg::LEVEL_W-1:0];
        reld_pkg::CFG_FULL_LEVEL:    cfg_r.full_level    <= cfg_data[reld_pkg::LEVEL_W-1:0];
        reld_pkg::CFG_RESTORE_LEVEL: cfg_r.restore_level <= cfg_data[reld_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: capture an event whenever the input side is not stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_take) begin
      item_vld_r <= 1'b1;
    end else if (advance) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode    <= in_mode;
      item_r.b_level <= in_b_level;
      item_r.time_ms <= in_time_ms;
    end
  end

  reld_step u_step (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // State is committed in the same cycle as the result, so the next event
  // in the input register always sees the up-to-date state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.last_button_time <= '0;
      state_r.last_rotary_time <= '0;
      state_r.press_flag       <= 1'b0;
      state_r.lamp_state       <= 1'b0;
      state_r.stored_level     <= reld_pkg::RST_FULL_LEVEL;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_level         = res_r.level;
  assign out_lamp_on       = res_r.lamp_on;
  assign out_level_written = res_r.level_written;
  assign out_accepted      = res_r.accepted;

endmodule

// ===== test/rotary_encoder_led_dimmer_unit_tb.sv =====
`timescale 1ns / 1ps

// Scoreboard for the dimmer. It keeps its own copy of the register settings and
// of the lamp state, works out the result that each accepted pin event must give,
// and compares the results leaving the block against those predictions in order.
class dimmer_scoreboard;

  // Register settings as last written.
  logic [reld_pkg::GAP_W-1:0]   button_gap;
  logic [reld_pkg::GAP_W-1:0]   rotary_gap;
  logic [reld_pkg::LEVEL_W-1:0] level_step;
  logic [reld_pkg::LEVEL_W-1:0] full_level;
  logic [reld_pkg::LEVEL_W-1:0] restore_level;

  // Lamp state.
  logic [reld_pkg::TIME_W-1:0]  last_press_ms;
  logic [reld_pkg::TIME_W-1:0]  last_detent_ms;
  logic                         press_held;
  logic                         lamp_lit;
  logic [reld_pkg::LEVEL_W-1:0] stored_level;

  reld_pkg::result_t lamp_outputs_due[$];

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned events_passed;
  int unsigned level_writes;
  int unsigned lit_results;

  function new();
    button_gap     = reld_pkg::RST_BUTTON_GAP;
    rotary_gap     = reld_pkg::RST_ROTARY_GAP;
    level_step     = reld_pkg::RST_LEVEL_STEP;
    full_level     = reld_pkg::RST_FULL_LEVEL;
    restore_level  = reld_pkg::RST_RESTORE_LEVEL;
    last_press_ms  = '0;
    last_detent_ms = '0;
    press_held     = 1'b0;
    lamp_lit       = 1'b0;
    stored_level   = reld_pkg::RST_FULL_LEVEL;
    mismatches     = 0;
    results_seen   = 0;
    events_passed  = 0;
    level_writes   = 0;
    lit_results    = 0;
  endfunction

  function void write_register(logic [reld_pkg::CFG_IDX_W-1:0] index,
                               logic [reld_pkg::CFG_DATA_W-1:0] value);
    case (index)
      reld_pkg::CFG_BUTTON_GAP:    button_gap    = value[reld_pkg::GAP_W-1:0];
      reld_pkg::CFG_ROTARY_GAP:    rotary_gap    = value[reld_pkg::GAP_W-1:0];
      reld_pkg::CFG_LEVEL_STEP:    level_step    = value[reld_pkg::LEVEL_W-1:0];
      reld_pkg::CFG_FULL_LEVEL:    full_level    = value[reld_pkg::LEVEL_W-1:0];
      reld_pkg::CFG_RESTORE_LEVEL: restore_level = value[reld_pkg::LEVEL_W-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned pending();
    return lamp_outputs_due.size();
  endfunction

  // Called for every pin event the block takes in; queues the result it must give.
  function void note_event(reld_pkg::item_t ev);
    reld_pkg::result_t want;
    int unsigned       lv;
    want = '0;
    if (ev.mode == reld_pkg::MODE_SWITCH) begin
      if (ev.time_ms - last_press_ms >= button_gap) begin
        want.accepted = 1'b1;
        last_press_ms = ev.time_ms;
        if (!press_held) begin
          press_held         = 1'b1;
          want.level_written = 1'b1;
          if (!lamp_lit) begin
            lamp_lit = 1'b1;
          end else if (stored_level == '0) begin
            stored_level = restore_level;
          end else begin
            lamp_lit = 1'b0;
          end
        end else begin
          press_held = 1'b0;
        end
      end
    end else begin
      if (ev.time_ms - last_detent_ms >= rotary_gap) begin
        want.accepted  = 1'b1;
        last_detent_ms = ev.time_ms;
        if (lamp_lit) begin
          lv = stored_level;
          if (ev.b_level == reld_pkg::DIR_UP && lv < full_level) begin
            lv = lv + level_step;
            if (lv >= full_level) begin
              lv = full_level;
            end
          end else if (ev.b_level == reld_pkg::DIR_DOWN && lv > 0) begin
            if (lv <= level_step) begin
              lv = 0;
            end else begin
              lv = lv - level_step;
            end
          end
          stored_level       = lv[reld_pkg::LEVEL_W-1:0];
          want.level_written = 1'b1;
        end
      end
    end
    want.lamp_on = lamp_lit;
    want.level   = lamp_lit ? stored_level : '0;
    if (want.accepted) begin
      events_passed++;
    end
    if (want.level_written) begin
      level_writes++;
    end
    if (want.lamp_on) begin
      lit_results++;
    end
    lamp_outputs_due.push_back(want);
  endfunction

  function void check_result(reld_pkg::result_t got);
    reld_pkg::result_t want;
    if (lamp_outputs_due.size() == 0) begin
      $error("result transfer with no pending event: level %0d lamp_on %0b",
             got.level, got.lamp_on);
      mismatches++;
      return;
    end
    want = lamp_outputs_due.pop_front();
    results_seen++;
    if (got.level !== want.level) begin
      $error("level: expected %0d, got %0d", want.level, got.level);
      mismatches++;
    end
    if (got.lamp_on !== want.lamp_on) begin
      $error("lamp_on: expected %0b, got %0b", want.lamp_on, got.lamp_on);
      mismatches++;
    end
    if (got.level_written !== want.level_written) begin
      $error("level_written: expected %0b, got %0b", want.level_written,
             got.level_written);
      mismatches++;
    end
    if (got.accepted !== want.accepted) begin
      $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
      mismatches++;
    end
  endfunction

  function void report_leftover();
    if (lamp_outputs_due.size() != 0) begin
      $error("%0d predicted results never arrived", lamp_outputs_due.size());
      mismatches += lamp_outputs_due.size();
    end
  endfunction

endclass

module rotary_encoder_led_dimmer_unit_tb;

  import reld_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_mode;
  logic                  in_b_level;
  logic [TIME_W-1:0]     in_time_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic [LEVEL_W-1:0]    out_level;
  logic                  out_lamp_on;
  logic                  out_level_written;
  logic                  out_accepted;

  dimmer_scoreboard lamp_tracker = new();

  // Percentage of cycles in which the sender holds back and the receiver stalls.
  // Dropped to zero for a stretch so that back-to-back transfers are also seen.
  int unsigned idle_pct = 34;

  // The receiver compares these two to notice that a long hold-off is wanted;
  // only the stimulus process bumps the request count, only the receiver the other.
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;

  // Running millisecond clock from which event time stamps are drawn.
  logic [TIME_W-1:0] now_ms;
  int unsigned       settings_applied = 0;

  rotary_encoder_led_dimmer_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_b_level        (in_b_level),
    .in_time_ms        (in_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_level         (out_level),
    .out_lamp_on       (out_lamp_on),
    .out_level_written (out_level_written),
    .out_accepted      (out_accepted)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog. A correct run finishes well before this point, so reaching this
  // point means the block has hung or lost transfers.
  initial begin
    #400000;
    $display("rotary_encoder_led_dimmer_unit verification failed");
    $finish;
  end

  // Result side. The stall is changed at the falling edge and a transfer is taken
  // at the rising edge when valid is high and stall is low. A long hold-off,
  // when asked for, is counted down here cycle by cycle.
  initial begin : result_sink
    int unsigned       hold_left;
    result_t           got;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = 120;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < idle_pct);
      end
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid && !out_stall) begin
        got.level         = out_level;
        got.lamp_on       = out_lamp_on;
        got.level_written = out_level_written;
        got.accepted      = out_accepted;
        lamp_tracker.check_result(got);
      end
    end
  end

  // Offers one pin event and returns at the falling edge after its transfer.
  // It is entered at a falling edge; any idle cycles come first, so valid is
  // only ever lowered in a step where it is not also raised.
  task automatic send_event(input logic mode, input logic b_level,
                            input logic [TIME_W-1:0] stamp);
    item_t ev;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_b_level <= b_level;
    in_time_ms <= stamp;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    ev.mode    = mode;
    ev.b_level = b_level;
    ev.time_ms = stamp;
    lamp_tracker.note_event(ev);
    @(negedge clk);
  endtask

  // Lowers valid and waits for every predicted result, with a bound so that a
  // lost result shows up as a leftover rather than a hang. Every event gives a
  // result, so once the queue is empty the block holds nothing in flight.
  task automatic drain_events();
    int unsigned waited;
    waited = 0;
    in_valid <= 1'b0;
    while (lamp_tracker.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(negedge clk);
  endtask

  // Writes all five registers on consecutive cycles, only ever while idle.
  task automatic apply_settings(input logic [GAP_W-1:0] btn_gap,
                                input logic [GAP_W-1:0] rot_gap,
                                input logic [LEVEL_W-1:0] step,
                                input logic [LEVEL_W-1:0] full,
                                input logic [LEVEL_W-1:0] restore);
    logic [CFG_IDX_W-1:0]  regs   [5];
    logic [CFG_DATA_W-1:0] values [5];
    regs   = '{CFG_BUTTON_GAP, CFG_ROTARY_GAP, CFG_LEVEL_STEP, CFG_FULL_LEVEL,
               CFG_RESTORE_LEVEL};
    values = '{btn_gap, rot_gap, CFG_DATA_W'(step), CFG_DATA_W'(full),
               CFG_DATA_W'(restore)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= values[i];
      @(negedge clk);
      lamp_tracker.write_register(regs[i], values[i]);
    end
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Random pin events. Most time steps clear the relevant gap by a little, so
  // presses and detents mostly get through and the lamp moves through its states;
  // the rest fall inside the gap or jump anywhere on the 32-bit clock.
  task automatic send_random_events(input int unsigned count);
    logic              mode;
    logic [TIME_W-1:0] gap;
    logic [TIME_W-1:0] delta;
    int unsigned       pick;
    for (int unsigned n = 0; n < count; n++) begin
      mode = ($urandom_range(99) < 25) ? MODE_SWITCH : MODE_ENCODER;
      gap  = (mode == MODE_SWITCH) ? TIME_W'(lamp_tracker.button_gap)
                                   : TIME_W'(lamp_tracker.rotary_gap);
      pick = $urandom_range(99);
      if (pick < 70) begin
        delta = $urandom_range(gap + gap / 2 + 8, gap);
      end else if (pick < 92) begin
        delta = $urandom_range(gap, 0);
      end else begin
        delta = $urandom;
      end
      now_ms = now_ms + delta;
      send_event(mode, 1'($urandom_range(1)), now_ms);
    end
  endtask

  initial begin : stimulus
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_BUTTON_GAP;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    in_mode    <= MODE_SWITCH;
    in_b_level <= DIR_UP;
    in_time_ms <= '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, starting from the reset settings. Both last-event times are
    // zero, so events in the first few milliseconds fall inside their gaps.
    send_event(MODE_SWITCH,  DIR_UP,   32'd0);
    send_event(MODE_SWITCH,  DIR_DOWN, 32'd19);
    send_event(MODE_ENCODER, DIR_UP,   32'd4);
    // A detent on an unlit lamp passes the gap but writes no level.
    send_event(MODE_ENCODER, DIR_DOWN, 32'd5);
    // Exactly on the gap: the lamp comes on at the stored full level.
    send_event(MODE_SWITCH,  DIR_DOWN, 32'd20);
    send_event(MODE_SWITCH,  DIR_UP,   32'd39);
    // The second accepted press only clears the pressed flag.
    send_event(MODE_SWITCH,  DIR_UP,   32'd40);
    // Up at full level: still written, level unchanged.
    send_event(MODE_ENCODER, DIR_UP,   32'd10);
    send_event(MODE_ENCODER, DIR_UP,   32'd14);
    send_event(MODE_ENCODER, DIR_DOWN, 32'd15);
    drain_events();

    // A step larger than the level takes it to zero, and a further step down
    // holds it there; a press while lit at zero brings back the restore level.
    apply_settings(RST_BUTTON_GAP, RST_ROTARY_GAP, 10'd1000, RST_FULL_LEVEL,
                   RST_RESTORE_LEVEL);
    send_event(MODE_ENCODER, DIR_DOWN, 32'd20);
    send_event(MODE_ENCODER, DIR_DOWN, 32'd25);
    send_event(MODE_SWITCH,  DIR_UP,   32'd60);
    send_event(MODE_SWITCH,  DIR_UP,   32'd80);
    send_event(MODE_SWITCH,  DIR_DOWN, 32'd100);
    send_event(MODE_ENCODER, DIR_UP,   32'd30);
    drain_events();

    // Full level lowered below the stored level: stepping up leaves it alone.
    // Then the time stamps wrap past the top of the 32-bit range.
    apply_settings(RST_BUTTON_GAP, RST_ROTARY_GAP, RST_LEVEL_STEP, 10'd100,
                   RST_RESTORE_LEVEL);
    send_event(MODE_SWITCH,  DIR_UP,   32'd120);
    send_event(MODE_SWITCH,  DIR_UP,   32'd140);
    send_event(MODE_ENCODER, DIR_UP,   32'd35);
    send_event(MODE_ENCODER, DIR_DOWN, 32'd40);
    send_event(MODE_ENCODER, DIR_UP,   32'hFFFF_FFFF);
    send_event(MODE_ENCODER, DIR_DOWN, 32'd3);
    send_event(MODE_ENCODER, DIR_DOWN, 32'd4);
    send_event(MODE_SWITCH,  DIR_DOWN, 32'hFFFF_FFF0);
    drain_events();
    now_ms = 32'hFFFF_FFF0;

    // Reset-like settings. Part way through, the receiver holds off for a long
    // stretch while events keep coming, so the block fills and stalls its input.
    apply_settings(RST_BUTTON_GAP, RST_ROTARY_GAP, RST_LEVEL_STEP, RST_FULL_LEVEL,
                   RST_RESTORE_LEVEL);
    send_random_events(60);
    hold_requests++;
    send_random_events(90);
    drain_events();

    // No debounce at all, unit step, widest level range, zero restore level.
    apply_settings(16'd0, 16'd0, 10'd1, 10'd1023, 10'd0);
    send_random_events(140);
    drain_events();

    // Longest gaps, a step of 1000, full level of one and a restore level above it.
    apply_settings(16'hFFFF, 16'hFFFF, 10'd1000, 10'd1, 10'd1023);
    send_random_events(120);
    drain_events();

    // A zero step leaves the level where it is.
    apply_settings(16'd3, 16'd2, 10'd0, 10'd512, 10'd256);
    send_random_events(120);
    drain_events();

    // Start just below the wrap point so the gap arithmetic crosses it.
    now_ms = 32'hFFFF_FF00;
    apply_settings(16'd1000, 16'd40, 10'd333, 10'd700, 10'd0);
    send_random_events(140);
    drain_events();

    // Odd sizes; the first 80 events run with neither side idling.
    apply_settings(16'd37, 16'd11, 10'd97, 10'd1023, 10'd1023);
    idle_pct = 0;
    send_random_events(80);
    idle_pct = 34;
    send_random_events(70);
    drain_events();
    repeat (8) @(posedge clk);

    lamp_tracker.report_leftover();
    $display("Checked %0d results over %0d register settings: %0d events passed debounce,",
             lamp_tracker.results_seen, settings_applied, lamp_tracker.events_passed);
    $display("%0d rewrote the level and %0d left the lamp lit.",
             lamp_tracker.level_writes, lamp_tracker.lit_results);
    if (lamp_tracker.mismatches == 0) begin
      $display("rotary_encoder_led_dimmer_unit verification clean");
    end else begin
      $display("rotary_encoder_led_dimmer_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/reld_pkg.sv
sv/reld_step.sv
sv/rotary_encoder_led_dimmer_unit.sv
test/rotary_encoder_led_dimmer_unit_tb.sv
